FILE: sv/csl_pkg.sv
package csl_pkg;

    localparam int NUM_KEYWORDS = 11;
    localparam int TEXT_CHARS   = 8;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_WORD = 3'd1,
        M_INT  = 3'd2,
        M_REAL = 3'd3,
        M_EQ   = 3'd4,
        M_LT   = 3'd5,
        M_GT   = 3'd6
    } scan_mode_t;

    localparam logic [5:0] K_UNDEF = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd12;
    localparam logic [5:0] K_INT   = 6'd13;
    localparam logic [5:0] K_REAL  = 6'd14;
    localparam logic [5:0] K_PLUS  = 6'd15;
    localparam logic [5:0] K_MINUS = 6'd16;
    localparam logic [5:0] K_STAR  = 6'd17;
    localparam logic [5:0] K_SLASH = 6'd18;
    localparam logic [5:0] K_ASSIGN = 6'd19;
    localparam logic [5:0] K_EQEQ  = 6'd20;
    localparam logic [5:0] K_LT    = 6'd21;
    localparam logic [5:0] K_LE    = 6'd22;
    localparam logic [5:0] K_GT    = 6'd23;
    localparam logic [5:0] K_GE    = 6'd24;
    localparam logic [5:0] K_LPAR  = 6'd25;
    localparam logic [5:0] K_RPAR  = 6'd26;
    localparam logic [5:0] K_LBRK  = 6'd27;
    localparam logic [5:0] K_RBRK  = 6'd28;
    localparam logic [5:0] K_LBRC  = 6'd29;
    localparam logic [5:0] K_RBRC  = 6'd30;
    localparam logic [5:0] K_COMMA = 6'd31;
    localparam logic [5:0] K_SEMI  = 6'd32;

    localparam logic [7:0] C_DOT = 8'h2E;
    localparam logic [7:0] C_EQ  = 8'h3D;
    localparam logic [7:0] C_NL  = 8'h0A;
    localparam logic [7:0] C_TAB = 8'h09;
    localparam logic [7:0] C_SP  = 8'h20;
    localparam logic [7:0] C_LT  = 8'h3C;
    localparam logic [7:0] C_GT  = 8'h3E;

    // Keyword table: packed text (first char in low byte) and length.
    localparam logic [63:0] KW_TEXT [16] = '{
        64'h00000000_64696F76, 64'h00000000_6E69616D, 64'h00000000_00746E69,
        64'h0000656C_62756F64, 64'h00000000_00726F66, 64'h00000065_6C696877,
        64'h00006863_74697773, 64'h00000000_65736163, 64'h00000000_00006669,
        64'h00000000_65736C65, 64'h00006E72_75746572, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0
    };
    localparam logic [7:0] KW_LEN [16] = '{
        8'd4, 8'd4, 8'd3, 8'd6, 8'd3, 8'd5, 8'd6, 8'd4, 8'd2, 8'd4, 8'd6,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] line_number;
        logic [63:0] token_text;
        logic [7:0]  text_length;
        logic        text_truncated;
        logic [31:0] digit_value;
        logic [7:0]  fraction_digits;
        logic        value_saturated;
        logic        last_of_run;
    } out_item_t;

endpackage

FILE: sv/c_subset_lexer.sv
// Streaming tokenizer for a small C subset.
// in channel: one source byte per transfer (in_valid/in_ready, payload
// in_data), with end_of_text on the last byte to flush any pending token.
// out channel: token items (out_valid/out_ready, payload out_data); one
// byte gives zero, one or two tokens, last_of_run marks the final one.
// Throughput: one byte per cycle while the receiver keeps up and the byte
// yields at most one token; after a byte that yields two tokens the next byte
// waits until the held second token has moved into the single output register.
// A byte's first token is on out_data in the cycle after the byte is taken.
// The scan state updates in the same cycle the byte is taken, so the
// keyword compares and the digit multiply-by-ten sit in one stage.
// Reset: scanner idle, pending token cleared, line count one, no output.
// Receiver stall: out_data holds; in_ready stays high while the output
// slot and second-token slot can absorb the next byte's tokens.
module c_subset_lexer
    import csl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    scan_mode_t  mode_reg, mode_next;
    logic [63:0] text_reg, text_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] val_reg, val_next;
    logic [7:0]  frac_reg, frac_next;
    logic        sat_reg, sat_next;
    logic [15:0] line_reg, line_next;

    out_item_t   out_reg;
    logic        out_v_reg;
    out_item_t   hold_reg;
    logic        hold_v_reg;

    out_item_t   t0, t1;
    logic        v0, v1;

    logic        accept;
    logic        out_free;

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_v_reg || out_ready;
    // Space for two tokens exists when nothing is held and the output slot frees.
    assign in_ready  = !hold_v_reg && out_free;
    assign accept    = in_valid && in_ready;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Scanner next state and the tokens emitted by the current byte.
    always_comb
    begin
        logic [7:0]  c;
        logic        done;
        logic [5:0]  kind;
        logic [35:0] prod;
        scanner_vars : begin end
        c = in_data.ch;
        mode_next = mode_reg;
        text_next = text_reg;
        len_next  = len_reg;
        val_next  = val_reg;
        frac_next = frac_reg;
        sat_next  = sat_reg;
        line_next = line_reg;
        done = 1'b0;
        kind = K_UNDEF;
        prod = '0;
        v0 = 1'b0;
        v1 = 1'b0;
        t0 = '0;
        t1 = '0;

        unique case (mode_reg)
            M_WORD:
                if (is_letter(c) || is_digit(c)) done = 1'b1;
            M_INT:
                if (is_digit(c) || c == C_DOT) done = 1'b1;
            M_REAL:
                if (is_digit(c)) done = 1'b1;
            M_EQ, M_LT, M_GT:
                if (c == C_EQ) done = 1'b1;
            default:
                done = 1'b0;
        endcase

        if (done) begin
            // Continue the pending token with this byte.
            if (len_reg < 8'(TEXT_CHARS))
                text_next = text_reg | (64'(c) << {len_reg[2:0], 3'b000});
            if (len_reg != 8'hFF)
                len_next = len_reg + 8'd1;
            if (is_digit(c) && (mode_reg == M_INT || mode_reg == M_REAL)) begin
                prod = {val_reg, 3'b000} + {2'b00, val_reg, 1'b0} + 36'(c - 8'h30);
                if (prod[35:32] != 4'd0) begin
                    val_next = 32'hFFFFFFFF;
                    sat_next = 1'b1;
                end else begin
                    val_next = prod[31:0];
                end
            end
            if (mode_reg == M_INT && c == C_DOT)
                mode_next = M_REAL;
            if (mode_reg == M_REAL && frac_reg != 8'hFF)
                frac_next = frac_reg + 8'd1;
            if (mode_reg == M_EQ || mode_reg == M_LT || mode_reg == M_GT) begin
                v0 = 1'b1;
                t0.token_kind  = (mode_reg == M_EQ) ? K_EQEQ
                               : (mode_reg == M_LT) ? K_LE : K_GE;
                t0.line_number = line_reg;
                t0.token_text  = text_next;
                t0.text_length = len_next;
                t0.text_truncated = len_next > 8'(TEXT_CHARS);
                mode_next = M_IDLE;
                text_next = '0; len_next = '0; val_next = '0;
                frac_next = '0; sat_next = 1'b0;
            end
        end else begin
            // Flush whatever was pending.
            if (mode_reg != M_IDLE) begin
                v0 = 1'b1;
                t0.line_number    = line_reg;
                t0.token_text     = text_reg;
                t0.text_length    = len_reg;
                t0.text_truncated = len_reg > 8'(TEXT_CHARS);
                unique case (mode_reg)
                    M_WORD:
                    begin
                        t0.token_kind = K_IDENT;
                        for (int i = NUM_KEYWORDS - 1; i >= 0; i--)
                            if (KW_LEN[i] != 8'd0 && KW_LEN[i] == len_reg &&
                                KW_TEXT[i] == text_reg)
                                t0.token_kind = 6'(i + 1);
                    end
                    M_INT:
                    begin
                        t0.token_kind = K_INT;
                        t0.digit_value = val_reg;
                        t0.value_saturated = sat_reg;
                    end
                    M_REAL:
                    begin
                        t0.token_kind = K_REAL;
                        t0.digit_value = val_reg;
                        t0.fraction_digits = frac_reg;
                        t0.value_saturated = sat_reg;
                    end
                    M_EQ:    t0.token_kind = K_ASSIGN;
                    M_LT:    t0.token_kind = K_LT;
                    default: t0.token_kind = K_GT;
                endcase
            end
            mode_next = M_IDLE;
            text_next = '0; len_next = '0; val_next = '0;
            frac_next = '0; sat_next = 1'b0;

            // Scan the byte afresh.
            if (c == C_SP || c == C_TAB) begin
                kind = K_UNDEF;
            end else if (c == C_NL) begin
                if (line_reg != 16'hFFFF)
                    line_next = line_reg + 16'd1;
            end else if (is_letter(c) || is_digit(c) ||
                         c == C_EQ || c == C_LT || c == C_GT) begin
                mode_next = is_letter(c) ? M_WORD
                          : is_digit(c)  ? M_INT
                          : (c == C_EQ)  ? M_EQ
                          : (c == C_LT)  ? M_LT : M_GT;
                text_next = 64'(c);
                len_next  = 8'd1;
                if (is_digit(c))
                    val_next = 32'(c - 8'h30);
            end else begin
                case (c)
                    8'h2B:   kind = K_PLUS;
                    8'h2D:   kind = K_MINUS;
                    8'h2A:   kind = K_STAR;
                    8'h2F:   kind = K_SLASH;
                    8'h28:   kind = K_LPAR;
                    8'h29:   kind = K_RPAR;
                    8'h5B:   kind = K_LBRK;
                    8'h5D:   kind = K_RBRK;
                    8'h7B:   kind = K_LBRC;
                    8'h7D:   kind = K_RBRC;
                    8'h2C:   kind = K_COMMA;
                    8'h3B:   kind = K_SEMI;
                    default: kind = K_UNDEF;
                endcase
                v1 = 1'b1;
                t1.token_kind  = kind;
                t1.line_number = line_reg;
                t1.token_text  = 64'(c);
                t1.text_length = 8'd1;
            end
        end

        // End of text flushes the token still pending after this byte.
        if (in_data.end_of_text && mode_next != M_IDLE) begin
            v1 = 1'b1;
            t1 = '0;
            t1.line_number    = line_next;
            t1.token_text     = text_next;
            t1.text_length    = len_next;
            t1.text_truncated = len_next > 8'(TEXT_CHARS);
            unique case (mode_next)
                M_WORD:
                begin
                    t1.token_kind = K_IDENT;
                    for (int i = NUM_KEYWORDS - 1; i >= 0; i--)
                        if (KW_LEN[i] != 8'd0 && KW_LEN[i] == len_next &&
                            KW_TEXT[i] == text_next)
                            t1.token_kind = 6'(i + 1);
                end
                M_INT:
                begin
                    t1.token_kind = K_INT;
                    t1.digit_value = val_next;
                    t1.value_saturated = sat_next;
                end
                M_REAL:
                begin
                    t1.token_kind = K_REAL;
                    t1.digit_value = val_next;
                    t1.fraction_digits = frac_next;
                    t1.value_saturated = sat_next;
                end
                M_EQ:    t1.token_kind = K_ASSIGN;
                M_LT:    t1.token_kind = K_LT;
                default: t1.token_kind = K_GT;
            endcase
            mode_next = M_IDLE;
            text_next = '0; len_next = '0; val_next = '0;
            frac_next = '0; sat_next = 1'b0;
        end

        t0.last_of_run = !v1;
        t1.last_of_run = 1'b1;
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            text_reg <= '0;
            len_reg  <= '0;
            val_reg  <= '0;
            frac_reg <= '0;
            sat_reg  <= 1'b0;
            line_reg <= 16'd1;
        end else if (accept) begin
            mode_reg <= mode_next;
            text_reg <= text_next;
            len_reg  <= len_next;
            val_reg  <= val_next;
            frac_reg <= frac_next;
            sat_reg  <= sat_next;
            line_reg <= line_next;
        end
    end

    // Output register with one held slot for a second token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (hold_v_reg) begin
                    out_v_reg  <= 1'b1;
                    hold_v_reg <= 1'b0;
                end else if (accept && (v0 || v1)) begin
                    out_v_reg  <= 1'b1;
                    hold_v_reg <= v0 && v1;
                end else begin
                    out_v_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (hold_v_reg)
                out_reg <= hold_reg;
            else if (accept)
                out_reg <= v0 ? t0 : t1;
        end
        if (accept && v0 && v1)
            hold_reg <= t1;
    end

`ifndef SYNTHESIS
    // The held slot only ever fills behind a waiting output.
    a_hold_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> out_v_reg)
        else $error("held token without output token");

    // A held token is always the last of its run.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> hold_reg.last_of_run)
        else $error("held token not last of run");

    // No byte is taken while a second token waits.
    a_no_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg |-> !in_ready)
        else $error("input accepted with token held");
`endif

endmodule
